// ----- hw/rtl/udp_fragment_link_tracker_top_macros.svh -----
// ----------------------------------------------------------------------------
// UDP fragment link tracker assertion macros
// Shared concurrent assertion forms for the tracker RTL.
// ----------------------------------------------------------------------------
`ifndef UDP_FRAGMENT_LINK_TRACKER_TOP_MACROS_SVH
`define UDP_FRAGMENT_LINK_TRACKER_TOP_MACROS_SVH

// same-cycle implication
`define UFL_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define UFL_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ufl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufl_pkg
// Types, codes and constants of the UDP fragment link tracker.
// ----------------------------------------------------------------------------
package ufl_pkg;

    localparam int unsigned DEF_PACKET_BYTES  = 1024;
    localparam int unsigned DEF_MAX_FRAGMENTS = 128;
    localparam int unsigned DEF_PENDING_DEPTH = 16;

    localparam int unsigned HEADER_BYTES = 4;
    localparam int unsigned DELIM_BYTES  = 2;   // CRLF appended to each message

    localparam int TIMEOUT_W = 24;
    localparam int TIMER_W   = 25;
    localparam int PENDING_W = 5;
    localparam int MSG_LEN_W = 20;
    localparam int TOTAL_W   = MSG_LEN_W + 1;
    localparam int CFG_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [TIMEOUT_W-1:0] RST_DISCONNECT_MS = 24'd10000;
    localparam logic [TIMEOUT_W-1:0] RST_PING_MS       = 24'd1000;
    localparam logic [TIMEOUT_W-1:0] RST_RETRY_MS      = 24'd500;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_PACKET = 2'd1,
        OP_SEND   = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        PT_EXIT    = 3'd0,
        PT_PONG    = 3'd1,
        PT_PING    = 3'd2,
        PT_SUCCESS = 3'd3,
        PT_USER    = 3'd4
    } ptype_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_TOO_LONG     = 3'd1,
        ST_EMPTY        = 3'd2,
        ST_BAD_TYPE     = 3'd3,
        ST_SHORT_HEADER = 3'd4,
        ST_TOO_BIG      = 3'd5,
        ST_PENDING_FULL = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        REG_DISCONNECT = 2'd0,
        REG_PING       = 2'd1,
        REG_RETRY      = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]           operation;
        logic [15:0]          elapsed_ms;
        logic [15:0]          packet_length;
        logic [2:0]           packet_type;
        logic [7:0]           packet_id;
        logic [7:0]           fragment_index;
        logic [7:0]           fragment_count;
        logic [MSG_LEN_W-1:0] msg_bytes;
    } in_item_t;

    typedef struct packed {
        logic       disconnect;
        logic       send_ping;
        logic       send_pong;
        logic       send_success;
        logic       resend_pending;
        logic       accept_payload;
        logic [2:0] status;
        logic [7:0] fragments_to_send;
        logic [7:0] assigned_id;
    } out_item_t;

    typedef struct packed {
        logic [TIMEOUT_W-1:0] disconnect_timeout_ms;
        logic [TIMEOUT_W-1:0] ping_timeout_ms;
        logic [TIMEOUT_W-1:0] retry_timeout_ms;
    } cfg_t;

endpackage

// ----- hw/rtl/ufl_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufl_regs
// APB-style register file holding the three timeout settings.
// ----------------------------------------------------------------------------
module ufl_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ufl_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [ufl_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ufl_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output ufl_pkg::cfg_t                  cfg
);
    import ufl_pkg::*;

    cfg_t     cfg_reg;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.disconnect_timeout_ms <= RST_DISCONNECT_MS;
            cfg_reg.ping_timeout_ms       <= RST_PING_MS;
            cfg_reg.retry_timeout_ms      <= RST_RETRY_MS;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_DISCONNECT: cfg_reg.disconnect_timeout_ms <= pwdata[TIMEOUT_W-1:0];
                REG_PING:       cfg_reg.ping_timeout_ms       <= pwdata[TIMEOUT_W-1:0];
                REG_RETRY:      cfg_reg.retry_timeout_ms      <= pwdata[TIMEOUT_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            REG_DISCONNECT: prdata = APB_DATA_W'(cfg_reg.disconnect_timeout_ms);
            REG_PING:       prdata = APB_DATA_W'(cfg_reg.ping_timeout_ms);
            REG_RETRY:      prdata = APB_DATA_W'(cfg_reg.retry_timeout_ms);
            default:        prdata = '0;
        endcase
    end

endmodule

// ----- hw/rtl/ufl_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufl_engine
// Link state registers and the single-pass decision logic for one item.
// ----------------------------------------------------------------------------
`include "udp_fragment_link_tracker_top_macros.svh"

module ufl_engine #(
    parameter int unsigned PACKET_BYTES  = ufl_pkg::DEF_PACKET_BYTES,
    parameter int unsigned MAX_FRAGMENTS = ufl_pkg::DEF_MAX_FRAGMENTS,
    parameter int unsigned PENDING_DEPTH = ufl_pkg::DEF_PENDING_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               commit,
    input  ufl_pkg::in_item_t  item,
    input  ufl_pkg::cfg_t      cfg,
    output ufl_pkg::out_item_t result
);
    import ufl_pkg::*;

    // fragment count = total / CHUNK + 1, the quotient by exact reciprocal multiply
    localparam int unsigned CHUNK   = PACKET_BYTES - HEADER_BYTES;
    localparam int          DIV_L   = $clog2(CHUNK);
    localparam int          DIV_SH  = TOTAL_W + DIV_L;
    localparam longint unsigned DIV_M =
        ((64'd1 << DIV_SH) + longint'(CHUNK) - 64'd1) / longint'(CHUNK);
    localparam int          DIV_MW  = TOTAL_W + 2;
    localparam int          PROD_W  = TOTAL_W + DIV_MW;
    localparam longint unsigned BIG_LIMIT = longint'(MAX_FRAGMENTS) * longint'(CHUNK);

    logic [TIMER_W-1:0]   de_reg, pe_reg, re_reg;
    logic [TIMER_W-1:0]   de_next, pe_next, re_next;
    logic [7:0]           em_reg, ef_reg, et_reg;
    logic [7:0]           em_next, ef_next, et_next;
    logic                 waiting_reg, waiting_next;
    logic [7:0]           next_id_reg, next_id_next;
    logic [PENDING_W-1:0] pending_reg, pending_next;

    logic [TIMER_W:0]     de_sum, pe_sum, re_sum;
    logic [TIMER_W-1:0]   de_sat, pe_sat, re_sat;
    logic [TOTAL_W-1:0]   total;
    logic [PROD_W-1:0]    prod, quo;
    logic                 too_big;
    logic [7:0]           frag_inc;
    logic                 in_order;

    // saturating timer advance
    assign de_sum = {1'b0, de_reg} + (TIMER_W + 1)'(item.elapsed_ms);
    assign pe_sum = {1'b0, pe_reg} + (TIMER_W + 1)'(item.elapsed_ms);
    assign re_sum = {1'b0, re_reg} + (TIMER_W + 1)'(item.elapsed_ms);
    assign de_sat = de_sum[TIMER_W] ? '1 : de_sum[TIMER_W-1:0];
    assign pe_sat = pe_sum[TIMER_W] ? '1 : pe_sum[TIMER_W-1:0];
    assign re_sat = re_sum[TIMER_W] ? '1 : re_sum[TIMER_W-1:0];

    assign total   = TOTAL_W'(item.msg_bytes) + TOTAL_W'(DELIM_BYTES);
    assign prod    = PROD_W'(total) * PROD_W'(DIV_M);
    assign quo     = prod >> DIV_SH;
    assign too_big = 64'(total) >= 64'(BIG_LIMIT);

    assign frag_inc = ef_reg + 8'd1;
    assign in_order = (item.packet_id == em_reg) && (item.fragment_index == ef_reg)
                   && (waiting_reg || (item.fragment_count == et_reg));

    always_comb
    begin
        result       = '0;
        de_next      = de_reg;
        pe_next      = pe_reg;
        re_next      = re_reg;
        em_next      = em_reg;
        ef_next      = ef_reg;
        et_next      = et_reg;
        waiting_next = waiting_reg;
        next_id_next = next_id_reg;
        pending_next = pending_reg;

        unique case (op_t'(item.operation))
            OP_TICK:
            begin
                de_next = de_sat;
                pe_next = pe_sat;
                re_next = re_sat;
                if (de_sat > {1'b0, cfg.disconnect_timeout_ms})
                begin
                    result.disconnect = 1'b1;   // ping and retry checks skipped
                end
                else
                begin
                    if (pe_sat > {1'b0, cfg.ping_timeout_ms})
                    begin
                        pe_next          = '0;
                        result.send_ping = 1'b1;
                    end
                    if (re_sat > {1'b0, cfg.retry_timeout_ms})
                    begin
                        result.resend_pending = (pending_reg != '0);
                        re_next               = '0;
                    end
                end
            end

            OP_PACKET:
            begin
                if (item.packet_length > 16'(PACKET_BYTES))
                begin
                    result.status = ST_TOO_LONG;
                end
                else if (item.packet_length == '0)
                begin
                    result.status = ST_EMPTY;
                end
                else
                begin
                    unique case (ptype_t'(item.packet_type))
                        PT_EXIT:    result.disconnect = 1'b1;
                        PT_PONG:    de_next = '0;
                        PT_PING:    result.send_pong = 1'b1;
                        PT_SUCCESS:
                        begin
                            if (pending_reg != '0)
                            begin
                                pending_next = pending_reg - PENDING_W'(1);
                                re_next      = '0;
                            end
                        end
                        PT_USER:
                        begin
                            if (item.packet_length < 16'(HEADER_BYTES))
                            begin
                                result.status = ST_SHORT_HEADER;
                            end
                            else if (in_order)
                            begin
                                if (frag_inc == item.fragment_count)
                                begin
                                    // last fragment: message complete
                                    waiting_next        = 1'b1;
                                    et_next             = '0;
                                    ef_next             = '0;
                                    em_next             = em_reg + 8'd1;
                                    result.send_success = 1'b1;
                                end
                                else
                                begin
                                    waiting_next = 1'b0;
                                    et_next      = item.fragment_count;
                                    ef_next      = frag_inc;
                                end
                                re_next               = '0;
                                result.accept_payload = 1'b1;
                            end
                        end
                        default:    result.status = ST_BAD_TYPE;
                    endcase
                end
            end

            OP_SEND:
            begin
                if (too_big)
                begin
                    result.status = ST_TOO_BIG;
                end
                else if (pending_reg >= PENDING_W'(PENDING_DEPTH))
                begin
                    result.status = ST_PENDING_FULL;
                end
                else
                begin
                    de_next                  = '0;
                    result.fragments_to_send = quo[7:0] + 8'd1;
                    result.assigned_id       = next_id_reg;
                    next_id_next             = next_id_reg + 8'd1;
                    pending_next             = pending_reg + PENDING_W'(1);
                end
            end

            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            de_reg      <= '0;
            pe_reg      <= '0;
            re_reg      <= '0;
            em_reg      <= '0;
            ef_reg      <= '0;
            et_reg      <= '0;
            waiting_reg <= 1'b1;
            next_id_reg <= '0;
            pending_reg <= '0;
        end
        else if (commit)
        begin
            de_reg      <= de_next;
            pe_reg      <= pe_next;
            re_reg      <= re_next;
            em_reg      <= em_next;
            ef_reg      <= ef_next;
            et_reg      <= et_next;
            waiting_reg <= waiting_next;
            next_id_reg <= next_id_next;
            pending_reg <= pending_next;
        end
    end

    `UFL_ASSERT_IMP(a_pending_bound, clk, rst_n, 1'b1, pending_reg <= PENDING_W'(PENDING_DEPTH), "pending over depth")
    `UFL_ASSERT_IMP(a_waiting_clean, clk, rst_n, waiting_reg, (et_reg == '0) && (ef_reg == '0), "stale fragments")
    `UFL_ASSERT_NXT(a_full_no_change, clk, rst_n, commit && (result.status == ST_PENDING_FULL), $stable(pending_reg) && $stable(next_id_reg), "refused send changed state")

endmodule

// ----- hw/rtl/udp_fragment_link_tracker_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udp_fragment_link_tracker_top
// Link-state tracker for a small reliable UDP scheme.
//
// Input channel (in_valid/in_stall/in_data) carries ticks, received packet
// headers and local send requests; output channel (out_valid/out_stall/
// out_data) returns exactly one result transaction per input transaction,
// in order. Timeouts are set over the APB-style port (0x0 disconnect,
// 0x4 ping, 0x8 retry); the user must set them only while the block is
// idle, which the block does not enforce. An accepted item waits in the
// input register; its result goes into the result register as it advances.
// Throughput: one transaction per cycle while out_stall is low; the link
// state is read and updated in the single logic pass between those two
// registers, so consecutive items see each other's effect with no bubble.
// When out_stall holds a finished result, the item in the input register
// waits and in_stall rises only once the input register is also occupied.
// Reset clears both pipeline stages, restores default timeouts and returns
// the link state to its initial values; no clearing sweep is needed.
// ----------------------------------------------------------------------------
`include "udp_fragment_link_tracker_top_macros.svh"

module udp_fragment_link_tracker_top #(
    parameter int unsigned PACKET_BYTES  = ufl_pkg::DEF_PACKET_BYTES,
    parameter int unsigned MAX_FRAGMENTS = ufl_pkg::DEF_MAX_FRAGMENTS,
    parameter int unsigned PENDING_DEPTH = ufl_pkg::DEF_PENDING_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  ufl_pkg::in_item_t              in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output ufl_pkg::out_item_t             out_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ufl_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [ufl_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ufl_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import ufl_pkg::*;

    cfg_t      cfg;
    in_item_t  in_data_reg;
    logic      in_valid_reg;
    out_item_t out_data_reg;
    logic      out_valid_reg;
    out_item_t result;
    logic      advance;
    logic      accept;

    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    ufl_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ufl_engine #(
        .PACKET_BYTES  (PACKET_BYTES),
        .MAX_FRAGMENTS (MAX_FRAGMENTS),
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (advance),
        .item   (in_data_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_data_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    `UFL_ASSERT_NXT(a_advance_result, clk, rst_n, advance, out_valid_reg, "committed transaction produced no result")
    `UFL_ASSERT_NXT(a_accept_loads, clk, rst_n, accept, in_valid_reg, "accepted transaction not held in input stage")
    `UFL_ASSERT_IMP(a_empty_no_stall, clk, rst_n, !in_valid_reg, !in_stall, "stall raised with empty input stage")

endmodule

// ----- verif/udp_fragment_link_tracker_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udp_fragment_link_tracker_checker
// Passive checker for the link tracker. It follows timeout writes on the
// config port, predicts one response per accepted input transaction and
// compares every accepted output transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module udp_fragment_link_tracker_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  ufl_pkg::in_item_t              in_data,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  ufl_pkg::out_item_t             out_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic                           pready,
    input  logic [ufl_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [ufl_pkg::APB_DATA_W-1:0] pwdata,
    output int                             fail_count,
    output int                             outstanding,
    output int                             checked
);
    import ufl_pkg::*;

    localparam int unsigned CHUNK_BYTES = DEF_PACKET_BYTES - HEADER_BYTES;
    localparam int unsigned SEND_LIMIT  = DEF_MAX_FRAGMENTS * CHUNK_BYTES;
    localparam int          RESP_SLOTS  = 64;

    cfg_t                 cfg;
    logic [TIMER_W-1:0]   disc_timer;
    logic [TIMER_W-1:0]   ping_timer;
    logic [TIMER_W-1:0]   retry_timer;
    logic [7:0]           rx_msg;
    logic [7:0]           rx_frag;
    logic [7:0]           rx_total;
    logic                 rx_need_total;
    logic [7:0]           tx_id;
    logic [PENDING_W-1:0] unacked;

    // ring of predicted responses, oldest at rd_count
    out_item_t awaited_responses [RESP_SLOTS];
    int        wr_count;
    int        rd_count;
    int        errors;
    int        seen;

    // timers stick at all ones instead of wrapping
    function automatic logic [TIMER_W-1:0] timer_add(logic [TIMER_W-1:0] t,
                                                     logic [15:0] d);
        logic [TIMER_W:0] s;
        s = {1'b0, t} + d;
        return s[TIMER_W] ? {TIMER_W{1'b1}} : s[TIMER_W-1:0];
    endfunction

    function automatic string resp_text(out_item_t r);
        return $sformatf("disc=%0b ping=%0b pong=%0b succ=%0b resend=%0b acc=%0b st=%0d frags=%0d id=%0d",
                         r.disconnect, r.send_ping, r.send_pong, r.send_success,
                         r.resend_pending, r.accept_payload, r.status,
                         r.fragments_to_send, r.assigned_id);
    endfunction

    task automatic predict_link_response(input in_item_t it, output out_item_t r);
        logic [TOTAL_W-1:0] total;
        int unsigned        frags;
        r = '0;
        case (it.operation)
            OP_TICK:
            begin
                disc_timer  = timer_add(disc_timer, it.elapsed_ms);
                ping_timer  = timer_add(ping_timer, it.elapsed_ms);
                retry_timer = timer_add(retry_timer, it.elapsed_ms);
                // a timed-out link reports only the disconnect
                if (disc_timer > {1'b0, cfg.disconnect_timeout_ms})
                begin
                    r.disconnect = 1'b1;
                end
                else
                begin
                    if (ping_timer > {1'b0, cfg.ping_timeout_ms})
                    begin
                        ping_timer  = '0;
                        r.send_ping = 1'b1;
                    end
                    if (retry_timer > {1'b0, cfg.retry_timeout_ms})
                    begin
                        r.resend_pending = (unacked != '0);
                        retry_timer      = '0;
                    end
                end
            end
            OP_PACKET:
            begin
                if (it.packet_length > DEF_PACKET_BYTES)
                    r.status = ST_TOO_LONG;
                else if (it.packet_length == '0)
                    r.status = ST_EMPTY;
                else
                begin
                    case (it.packet_type)
                        PT_EXIT:    r.disconnect = 1'b1;
                        PT_PONG:    disc_timer = '0;
                        PT_PING:    r.send_pong = 1'b1;
                        PT_SUCCESS:
                        begin
                            if (unacked != '0)
                            begin
                                unacked     = unacked - 1'b1;
                                retry_timer = '0;
                            end
                        end
                        PT_USER:
                        begin
                            if (it.packet_length < HEADER_BYTES)
                                r.status = ST_SHORT_HEADER;
                            else if (it.packet_id == rx_msg && it.fragment_index == rx_frag &&
                                     (rx_need_total || it.fragment_count == rx_total))
                            begin
                                rx_total      = it.fragment_count;
                                rx_need_total = 1'b0;
                                rx_frag       = rx_frag + 8'd1;
                                // a total of zero completes only after the counter wraps
                                if (rx_frag == rx_total)
                                begin
                                    rx_need_total  = 1'b1;
                                    rx_total       = '0;
                                    rx_frag        = '0;
                                    rx_msg         = rx_msg + 8'd1;
                                    r.send_success = 1'b1;
                                end
                                retry_timer      = '0;
                                r.accept_payload = 1'b1;
                            end
                        end
                        default:    r.status = ST_BAD_TYPE;
                    endcase
                end
            end
            OP_SEND:
            begin
                total = TOTAL_W'(it.msg_bytes + DELIM_BYTES);
                if (total >= SEND_LIMIT)
                    r.status = ST_TOO_BIG;
                else if (unacked >= DEF_PENDING_DEPTH)
                    r.status = ST_PENDING_FULL;
                else
                begin
                    disc_timer          = '0;
                    frags               = total / CHUNK_BYTES + 1;
                    r.fragments_to_send = frags[7:0];
                    r.assigned_id       = tx_id;
                    tx_id               = tx_id + 8'd1;
                    unacked             = unacked + 1'b1;
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_item_t want;
        if (!rst_n)
        begin
            cfg           = {RST_DISCONNECT_MS, RST_PING_MS, RST_RETRY_MS};
            disc_timer    = '0;
            ping_timer    = '0;
            retry_timer   = '0;
            rx_msg        = '0;
            rx_frag       = '0;
            rx_total      = '0;
            rx_need_total = 1'b1;
            tx_id         = '0;
            unacked       = '0;
            wr_count      = 0;
            rd_count      = 0;
            errors        = 0;
            seen          = 0;
            fail_count  <= 0;
            outstanding <= 0;
            checked     <= 0;
        end
        else
        begin
            // output first: a response can never belong to this edge's input
            if (out_valid && !out_stall)
            begin
                if (wr_count == rd_count)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("[%0t] unexpected response: %s", $realtime,
                                 resp_text(out_data));
                end
                else
                begin
                    want = awaited_responses[rd_count % RESP_SLOTS];
                    rd_count++;
                    seen++;
                    if (out_data !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("[%0t] response %0d mismatch", $realtime, seen);
                            $display("    expected %s", resp_text(want));
                            $display("    actual   %s", resp_text(out_data));
                        end
                    end
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[CFG_ADDR_W-1:2])
                    REG_DISCONNECT: cfg.disconnect_timeout_ms = pwdata[TIMEOUT_W-1:0];
                    REG_PING:       cfg.ping_timeout_ms       = pwdata[TIMEOUT_W-1:0];
                    REG_RETRY:      cfg.retry_timeout_ms      = pwdata[TIMEOUT_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                predict_link_response(in_data, want);
                if (wr_count - rd_count >= RESP_SLOTS)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("[%0t] too many responses outstanding", $realtime);
                end
                else
                begin
                    awaited_responses[wr_count % RESP_SLOTS] = want;
                    wr_count++;
                end
            end
            fail_count  <= errors;
            outstanding <= wr_count - rd_count;
            checked     <= seen;
        end
    end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the UDP fragment link tracker: directed corner transactions,
// then random phases under several timeout settings, with random idling on
// both channels. The checker beside the block does prediction and compare.
// ----------------------------------------------------------------------------
module tb_top;
    import ufl_pkg::*;

    localparam logic [1:0] OP_UNUSED        = 2'd3;
    localparam logic [2:0] PT_BAD_FIRST     = 3'd5;
    localparam logic [2:0] PT_BAD_LAST      = 3'd7;
    localparam int         LONG_HOLD_CYCLES = 200;
    localparam int         SATURATE_TICKS   = 530;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_stall;
    out_item_t             out_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int outstanding;
    int checked;

    bit quiet;
    bit hold_req;
    int sent_count;

    // sender-side view of the in-order fragment stream
    logic [7:0] gen_msg;
    logic [7:0] gen_frag;
    logic [7:0] gen_total;
    bit         gen_waiting;
    bit         zero_total_next;
    bit         zero_in_flight;

    int unsigned tick_weight;
    int unsigned user_weight;
    int unsigned send_weight;
    int unsigned success_weight;
    int unsigned tick_span;

    always #5 clk = ~clk;

    udp_fragment_link_tracker_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    udp_fragment_link_tracker_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .checked     (checked)
    );

    // mostly short gaps, now and then a long one
    function automatic int unsigned idle_cycles();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    function automatic in_item_t tick_item(logic [15:0] ms);
        in_item_t it;
        it            = '0;
        it.operation  = OP_TICK;
        it.elapsed_ms = ms;
        return it;
    endfunction

    function automatic in_item_t pkt_item(logic [15:0] len, logic [2:0] kind,
                                          logic [7:0] id, logic [7:0] frag,
                                          logic [7:0] count);
        in_item_t it;
        it                = '0;
        it.operation      = OP_PACKET;
        it.packet_length  = len;
        it.packet_type    = kind;
        it.packet_id      = id;
        it.fragment_index = frag;
        it.fragment_count = count;
        return it;
    endfunction

    function automatic in_item_t send_msg(logic [MSG_LEN_W-1:0] bytes);
        in_item_t it;
        it           = '0;
        it.operation = OP_SEND;
        it.msg_bytes = bytes;
        return it;
    endfunction

    task automatic send_item(input in_item_t it);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat (idle_cycles()) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
        sent_count++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [TIMEOUT_W-1:0] value);
        logic [7:0] junk;
        junk = 8'($urandom);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {junk, value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_timeouts(input logic [TIMEOUT_W-1:0] disc_ms,
                                input logic [TIMEOUT_W-1:0] ping_ms,
                                input logic [TIMEOUT_W-1:0] retry_ms);
        write_reg(REG_DISCONNECT, disc_ms);
        write_reg(REG_PING, ping_ms);
        write_reg(REG_RETRY, retry_ms);
    endtask

    task automatic next_random_item(output in_item_t it);
        logic [95:0] raw;
        int unsigned pick;
        int unsigned alt;
        raw  = {$urandom, $urandom, $urandom};
        it   = raw[$bits(in_item_t)-1:0];
        pick = $urandom_range(0, 99);
        alt  = $urandom_range(0, 9);
        if (pick < tick_weight)
        begin
            it.operation = OP_TICK;
            if (alt == 0)
                it.elapsed_ms = '0;
            else if (alt == 1)
                it.elapsed_ms = 16'hFFFF;
            else if (alt > 2)
                it.elapsed_ms = 16'($urandom_range(0, tick_span));
        end
        else if (pick < tick_weight + user_weight)
        begin
            // next fragment of a well-formed message
            if (gen_waiting)
            begin
                if (zero_total_next)
                begin
                    gen_total       = '0;
                    zero_total_next = 1'b0;
                    zero_in_flight  = 1'b1;
                end
                else
                    gen_total = 8'($urandom_range(1, (alt == 0) ? 24 : 5));
                gen_waiting = 1'b0;
            end
            it.operation      = OP_PACKET;
            it.packet_type    = PT_USER;
            it.packet_length  = (alt == 0) ? 16'd4 : (alt == 1) ? 16'd1024 :
                                16'($urandom_range(4, 1024));
            it.packet_id      = gen_msg;
            it.fragment_index = gen_frag;
            it.fragment_count = gen_total;
            gen_frag          = gen_frag + 8'd1;
            if (gen_frag == gen_total)
            begin
                gen_frag       = '0;
                gen_msg        = gen_msg + 8'd1;
                gen_waiting    = 1'b1;
                zero_in_flight = 1'b0;
            end
        end
        else if (pick < tick_weight + user_weight + send_weight)
        begin
            it.operation = OP_SEND;
            case (alt)
                0: it.msg_bytes = 20'd1018;
                1: it.msg_bytes = 20'd2038;
                2: it.msg_bytes = 20'd130557;
                3: it.msg_bytes = 20'd130558;
                4: ;
                default: it.msg_bytes = 20'($urandom_range(0, 4000));
            endcase
        end
        else if (pick < tick_weight + user_weight + send_weight + success_weight)
        begin
            it.operation     = OP_PACKET;
            it.packet_type   = PT_SUCCESS;
            it.packet_length = 16'($urandom_range(1, 1024));
        end
        else
        begin
            // noise and broken sequences; none of it moves the fragment state
            it.operation     = OP_PACKET;
            it.packet_length = 16'($urandom_range(1, 1024));
            case (alt)
                0, 9: it.packet_type = PT_PONG;
                1:    it.packet_type = PT_PING;
                2:    it.packet_type = PT_EXIT;
                3:    it.packet_length = $urandom_range(0, 1) ? 16'd0 :
                                         16'($urandom_range(1025, 65535));
                4:    it.packet_type = 3'($urandom_range(PT_BAD_FIRST, PT_BAD_LAST));
                5:
                begin
                    it.packet_type   = PT_USER;
                    it.packet_length = 16'($urandom_range(1, HEADER_BYTES - 1));
                end
                6:
                begin
                    it.packet_type   = PT_USER;
                    it.packet_length = 16'($urandom_range(4, 1024));
                    it.packet_id     = gen_msg + 8'($urandom_range(1, 255));
                end
                7:
                begin
                    it.packet_type    = PT_USER;
                    it.packet_length  = 16'($urandom_range(4, 1024));
                    it.packet_id      = gen_msg;
                    it.fragment_index = gen_frag;
                    it.fragment_count = gen_total + 8'($urandom_range(1, 255));
                    if (gen_waiting || $urandom_range(0, 1))
                        it.fragment_index = gen_frag + 8'($urandom_range(1, 255));
                end
                default: it.operation = OP_UNUSED;
            endcase
        end
    endtask

    task automatic run_random(input int count);
        in_item_t it;
        for (int i = 0; i < count; i++)
        begin
            if (i % 64 == 0)
                quiet = ($urandom_range(0, 4) == 0);
            next_random_item(it);
            send_item(it);
        end
    endtask

    initial
    begin : receiver
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                for (int n = 0; n < LONG_HOLD_CYCLES; n++) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat (idle_cycles()) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin : stimulus
        in_item_t it;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        in_data         = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        quiet           = 1'b0;
        hold_req        = 1'b0;
        sent_count      = 0;
        zero_total_next = 1'b0;
        zero_in_flight  = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners under the reset timeouts
        it           = '1;
        it.operation = OP_UNUSED;
        send_item(it);
        send_item(tick_item(16'd0));
        send_item(tick_item(16'd500));
        send_item(tick_item(16'd1));        // retry fires with nothing pending
        send_item(tick_item(16'd499));      // ping exactly at its limit
        send_item(tick_item(16'd1));
        send_item(pkt_item(16'd0, PT_USER, 8'd0, 8'd0, 8'd1));
        send_item(pkt_item(16'd1025, PT_PING, 8'd0, 8'd0, 8'd0));
        send_item(pkt_item(16'hFFFF, PT_USER, 8'd0, 8'd0, 8'd1));
        send_item(pkt_item(16'd1, PT_BAD_FIRST, 8'd0, 8'd0, 8'd0));
        send_item(pkt_item(16'd1024, PT_BAD_LAST, 8'd0, 8'd0, 8'd0));
        send_item(pkt_item(16'd3, PT_USER, 8'd0, 8'd0, 8'd1));
        send_item(pkt_item(16'd8, PT_SUCCESS, 8'd0, 8'd0, 8'd0));
        send_item(send_msg(20'd0));
        send_item(send_msg(20'd1018));      // delimiter fills the chunk exactly
        send_item(send_msg(20'd130557));
        send_item(send_msg(20'd130558));
        send_item(send_msg(20'hFFFFF));
        send_item(pkt_item(16'd4, PT_USER, 8'd0, 8'd0, 8'd2));
        send_item(pkt_item(16'd100, PT_USER, 8'd0, 8'd0, 8'd2));
        send_item(pkt_item(16'd100, PT_USER, 8'd0, 8'd1, 8'd3));
        send_item(pkt_item(16'd100, PT_USER, 8'd1, 8'd1, 8'd2));
        send_item(pkt_item(16'd1024, PT_USER, 8'd0, 8'd1, 8'd2));
        send_item(pkt_item(16'd64, PT_SUCCESS, 8'd0, 8'd0, 8'd0));
        send_item(tick_item(16'd2000));
        send_item(pkt_item(16'd4, PT_PONG, 8'd0, 8'd0, 8'd0));
        send_item(tick_item(16'hFFFF));
        send_item(pkt_item(16'd4, PT_PING, 8'd0, 8'd0, 8'd0));
        send_item(pkt_item(16'd4, PT_EXIT, 8'd0, 8'd0, 8'd0));
        wait_idle();

        gen_msg     = 8'd1;
        gen_frag    = '0;
        gen_total   = '0;
        gen_waiting = 1'b1;

        // short timeouts, sends outnumber acks so the pending store fills
        set_timeouts(24'd3000, 24'd300, 24'd200);
        tick_weight    = 22;
        user_weight    = 30;
        send_weight    = 35;
        success_weight = 3;
        tick_span      = 400;
        run_random(30);
        hold_req = 1'b1;
        run_random(40);
        wait_idle();

        // zero timeouts
        set_timeouts(24'd0, 24'd0, 24'd0);
        tick_weight    = 35;
        user_weight    = 25;
        send_weight    = 10;
        success_weight = 8;
        tick_span      = 3;
        run_random(30);
        wait_idle();

        // random timeouts, mostly fragments, one message with a total of zero
        set_timeouts(24'($urandom_range(1, 20000)), 24'($urandom_range(1, 4000)),
                     24'($urandom_range(1, 3000)));
        tick_weight     = 4;
        user_weight     = 90;
        send_weight     = 2;
        success_weight  = 2;
        tick_span       = 2000;
        zero_total_next = 1'b1;
        run_random(20);
        while (zero_total_next || zero_in_flight)
        begin
            next_random_item(it);
            send_item(it);
        end
        run_random(10);
        wait_idle();

        // largest timeouts; long silence drives the disconnect timer to saturation
        set_timeouts(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        for (int i = 0; i < SATURATE_TICKS; i++)
        begin
            if (i % 64 == 0)
                quiet = ($urandom_range(0, 4) == 0);
            send_item(tick_item(16'hFFFF));
            if (i % 60 == 59)
                send_item(pkt_item(16'($urandom_range(1, 1024)), PT_PING, 8'd0, 8'd0, 8'd0));
        end
        send_item(pkt_item(16'd20, PT_PONG, 8'd0, 8'd0, 8'd0));
        send_item(tick_item(16'd1));
        send_item(tick_item(16'd0));
        wait_idle();

        // reset values again, acknowledgements drain the pending store
        set_timeouts(24'd10000, 24'd1000, 24'd500);
        tick_weight    = 25;
        user_weight    = 30;
        send_weight    = 5;
        success_weight = 25;
        tick_span      = 800;
        run_random(30);
        wait_idle();
        repeat (10) @(posedge clk);

        $display("Run covered %0d input transactions and %0d checked responses", sent_count,
                 checked);
        $display("over six timeout settings, timer saturation and a zero-total message.");
        if (fail_count == 0 && outstanding == 0)
            $display("** udp_fragment_link_tracker_top: PASSED **");
        else
            $display("** udp_fragment_link_tracker_top: FAILED **");
        $finish;
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("Timeout with %0d responses still awaited", outstanding);
        $display("** udp_fragment_link_tracker_top: FAILED **");
        $finish;
    end

endmodule
